### hdl/pfe_pkg.sv
// Shared constants, status codes and controller states for the postfix expression evaluator.
// Has no dependencies; the evaluator top level imports it.
`default_nettype none

package pfe_pkg;

  // Stack geometry and operand width
  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DIV_CNT_W   = $clog2(VALUE_WIDTH);

  // Expression characters
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  // Expression status, first error wins
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_DIVZ  = 2'd2,
    ST_OVER  = 2'd3
  } status_e;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_DWR,
    S_TOP,
    S_EMIT
  } state_e;

  // Record an error only if none was seen yet
  function automatic status_e note_err(input status_e cur, input status_e code);
    note_err = (cur == ST_OK) ? code : cur;
  endfunction

endpackage

`default_nettype wire

### hdl/postfix_expression_evaluator.sv
// Postfix evaluator: operand stack in a synchronous RAM with an iterative restoring divider.
// Each character is taken in S_IDLE and run in S_EXEC; a / then runs the bit-serial divider in
// S_DIV and writes the quotient in S_DWR. The last character adds S_TOP (top-of-stack read) and
// S_EMIT (result load). One transaction is in work at a time; the result register lets the next
// one start while the previous result waits. Async active-low reset clears stack count, status
// and handshake state; the stack RAM is not cleared (entries are written before they are read).
// Depends on pfe_pkg.
`default_nettype none

module postfix_expression_evaluator import pfe_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [7:0]                    symbol_i,
  input  wire logic                          last_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [VALUE_WIDTH-1:0]      value_o,
  output logic [1:0]                         status_o
);

  localparam logic [CNT_W-1:0]     CNT_FULL = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0]     CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0]     CNT_TWO  = CNT_W'(2);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(VALUE_WIDTH - 1);

  // Control state
  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        count_q, count_d;
  status_e                 err_q, err_d;
  logic                    out_valid_q;

  // Latched transaction
  logic [7:0]              sym_q;
  logic                    last_q;

  // Stack RAM and its registered read ports
  logic [VALUE_WIDTH-1:0]  stack_mem [STACK_DEPTH];
  logic [VALUE_WIDTH-1:0]  rd_a_q, rd_b_q;
  logic [ADDR_W-1:0]       rd_a_addr, rd_b_addr;
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic [VALUE_WIDTH-1:0]  wr_data;

  // Divider
  logic [VALUE_WIDTH:0]    rem_q;
  logic [VALUE_WIDTH-1:0]  quo_q, dvs_q;
  logic                    neg_q;
  logic [DIV_CNT_W-1:0]    div_cnt_q;
  logic [VALUE_WIDTH:0]    rem_shift, rem_trial;
  logic                    div_start;

  // Result register
  logic [VALUE_WIDTH-1:0]  value_q;
  status_e                 status_q;
  logic                    emit;

  // Decode and operands
  logic                    is_digit, under, div_go;
  logic [3:0]              digit;
  logic [CNT_W-1:0]        pop_cnt;
  logic [VALUE_WIDTH-1:0]  opnd_r, opnd_l, prod, mag_l, mag_r, quot;
  status_e                 err_pop;

  assign is_digit = (sym_q >= CHAR_ZERO) && (sym_q <= CHAR_NINE);
  assign digit    = 4'(sym_q - CHAR_ZERO);
  assign under    = count_q < CNT_TWO;
  assign pop_cnt  = under ? '0 : count_q - CNT_TWO;
  assign opnd_r   = (count_q >= CNT_ONE) ? rd_a_q : '0;
  assign opnd_l   = under ? '0 : rd_b_q;
  assign prod     = opnd_l * opnd_r;
  assign mag_l    = opnd_l[VALUE_WIDTH-1] ? (~opnd_l + 1'b1) : opnd_l;
  assign mag_r    = opnd_r[VALUE_WIDTH-1] ? (~opnd_r + 1'b1) : opnd_r;
  assign err_pop  = under ? note_err(err_q, ST_UNDER) : err_q;
  assign div_go   = !is_digit && (sym_q == CHAR_SLASH) && (opnd_r != '0);
  assign quot     = neg_q ? (~quo_q + 1'b1) : quo_q;

  // Read top two entries every cycle; data is used the cycle after
  assign rd_a_addr = count_q[ADDR_W-1:0] - ADDR_W'(1);
  assign rd_b_addr = count_q[ADDR_W-1:0] - ADDR_W'(2);

  // One restoring-division step
  assign rem_shift = {rem_q[VALUE_WIDTH-1:0], quo_q[VALUE_WIDTH-1]};
  assign rem_trial = rem_shift - {1'b0, dvs_q};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (div_go) state_d = S_DIV;
        else        state_d = last_q ? S_TOP : S_IDLE;
      end
      S_DIV: begin
        if (div_cnt_q == DIV_LAST) state_d = S_DWR;
      end
      S_DWR: begin
        state_d = last_q ? S_TOP : S_IDLE;
      end
      S_TOP: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath control: stack writes, count, status, divider start, result load
  always_comb begin
    in_ready_o = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = pop_cnt[ADDR_W-1:0];
    wr_data    = '0;
    count_d    = count_q;
    err_d      = err_q;
    div_start  = 1'b0;
    emit       = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
      end
      S_EXEC: begin
        if (is_digit) begin
          // push digit, drop it on a full stack
          if (count_q >= CNT_FULL) begin
            err_d = note_err(err_q, ST_OVER);
          end else begin
            wr_en   = 1'b1;
            wr_addr = count_q[ADDR_W-1:0];
            wr_data = VALUE_WIDTH'(digit);
            count_d = count_q + CNT_ONE;
          end
        end else begin
          err_d   = err_pop;
          count_d = pop_cnt;
          case (sym_q)
            CHAR_PLUS: begin
              wr_en   = 1'b1;
              wr_data = opnd_l + opnd_r;
              count_d = pop_cnt + CNT_ONE;
            end
            CHAR_MINUS: begin
              wr_en   = 1'b1;
              wr_data = opnd_l - opnd_r;
              count_d = pop_cnt + CNT_ONE;
            end
            CHAR_STAR: begin
              wr_en   = 1'b1;
              wr_data = prod;
              count_d = pop_cnt + CNT_ONE;
            end
            CHAR_SLASH: begin
              if (opnd_r == '0) begin
                err_d   = note_err(err_pop, ST_DIVZ);
                wr_en   = 1'b1;
                count_d = pop_cnt + CNT_ONE;
              end else begin
                div_start = 1'b1;
              end
            end
            default: begin
              // operands are discarded
            end
          endcase
        end
      end
      S_DWR: begin
        wr_en   = 1'b1;
        wr_addr = count_q[ADDR_W-1:0];
        wr_data = quot;
        count_d = count_q + CNT_ONE;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          emit    = 1'b1;
          count_d = '0;
          err_d   = ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      err_q   <= err_d;
      if (emit)             out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (div_start)            div_cnt_q <= '0;
      else if (state_q == S_DIV) div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  // Stack RAM: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) stack_mem[wr_addr] <= wr_data;
    rd_a_q <= stack_mem[rd_a_addr];
    rd_b_q <= stack_mem[rd_b_addr];
  end

  // Payload registers: transaction, divider, result
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sym_q  <= symbol_i;
      last_q <= last_i;
    end
    if (div_start) begin
      rem_q <= '0;
      quo_q <= mag_l;
      dvs_q <= mag_r;
      neg_q <= opnd_l[VALUE_WIDTH-1] ^ opnd_r[VALUE_WIDTH-1];
    end else if (state_q == S_DIV) begin
      if (!rem_trial[VALUE_WIDTH]) begin
        rem_q <= rem_trial;
        quo_q <= {quo_q[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem_q <= rem_shift;
        quo_q <= {quo_q[VALUE_WIDTH-2:0], 1'b0};
      end
    end
    if (emit) begin
      value_q  <= (count_q == '0) ? '0 : rd_a_q;
      status_q <= (count_q == '0) ? note_err(err_q, ST_UNDER) : err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL) else $error("stack count beyond depth");

  a_dwr_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DWR |-> $past(state_q == S_DIV)) else $error("quotient write without divide");

  a_rose_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT)) else $error("result without emit");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (count_q == '0) && (err_q == ST_OK)) else $error("stack not cleared after result");

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (state_q == S_DIV) && (div_cnt_q == '0)) else $error("divider start lost");

endmodule

`default_nettype wire

### verif/postfix_expression_evaluator_tb.sv
// Self-checking testbench for the postfix expression evaluator: a directed table of expressions
// followed by random ones, each checked against a cycle-free evaluation model or a typed-in result.
// Depends on pfe_pkg and postfix_expression_evaluator.
module postfix_expression_evaluator_tb;
  import pfe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_DIRECTED = 34;
  localparam int unsigned NUM_RANDOM   = 1330;
  localparam int unsigned PHASE_LEN    = 530;
  localparam int unsigned DRAIN_LIMIT  = 200000;
  localparam int unsigned TAIL_CYCLES  = 60;
  localparam int unsigned MAX_REPORTS  = 10;

  // One expression character as sent to the block
  typedef struct packed {
    logic [7:0] sym;
    logic       last;
  } char_t;

  // One evaluated expression
  typedef struct packed {
    logic [31:0] value;
    status_e     status;
  } result_t;

  // Directed row: a character sent reps times, optionally with a typed-in result
  typedef struct packed {
    logic [7:0]  sym;
    logic [6:0]  reps;
    logic        last;
    logic        typed;
    logic [31:0] value;
    status_e     status;
  } dir_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic [7:0]                    symbol_i = 8'h00;
  logic                          last_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic signed [VALUE_WIDTH-1:0] value_o;
  logic [1:0]                    status_o;

  // Evaluation model state
  logic [31:0] eval_stack [STACK_DEPTH];
  int unsigned eval_depth = 0;
  status_e     eval_status = ST_OK;

  result_t     pending_results [$];
  char_t       expr_chars [$];
  dir_row_t    directed_tbl [NUM_DIRECTED];

  int unsigned chars_sent = 0;
  int unsigned random_chars = 0;
  int unsigned expr_results = 0;
  int unsigned check_errors = 0;
  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 80;
  int unsigned status_tally [4] = '{0, 0, 0, 0};

  postfix_expression_evaluator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .symbol_i    (symbol_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .status_o    (status_o)
  );

  always #10 clk_i = ~clk_i;

  // Hold reset, then release it on a falling edge
  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Stall the result channel at the current rate
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Hard stop for a hung run
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_failure(input string what);
    check_errors++;
    if (check_errors <= MAX_REPORTS) begin
      $display("ERROR @%0t: %s", $time, what);
    end
  endtask

  // Keep only the first fault of an expression
  function automatic void record_fault(input status_e code);
    if (eval_status == ST_OK) begin
      eval_status = code;
    end
  endfunction

  function automatic void push_operand(input logic [31:0] v);
    if (eval_depth >= STACK_DEPTH) begin
      record_fault(ST_OVER);
    end else begin
      eval_stack[eval_depth] = v;
      eval_depth++;
    end
  endfunction

  function automatic logic [31:0] pop_operand();
    if (eval_depth == 0) begin
      record_fault(ST_UNDER);
      return 32'd0;
    end
    eval_depth--;
    return eval_stack[eval_depth];
  endfunction

  // Signed divide truncating toward zero, done on magnitudes so the
  // most negative value over minus one wraps instead of trapping
  function automatic logic [31:0] trunc_quotient(input logic [31:0] num, input logic [31:0] den);
    logic [31:0] num_mag;
    logic [31:0] den_mag;
    logic [31:0] quo;
    num_mag = num[31] ? -num : num;
    den_mag = den[31] ? -den : den;
    quo = num_mag / den_mag;
    return (num[31] ^ den[31]) ? -quo : quo;
  endfunction

  // Advance the model by one character; returns 1 when a result is due
  function automatic bit eval_symbol(input logic [7:0] sym, input logic last,
                                     output result_t res);
    logic [7:0]  digit_val;
    logic [31:0] rhs;
    logic [31:0] lhs;
    res.value  = 32'd0;
    res.status = ST_OK;
    if (sym >= CHAR_ZERO && sym <= CHAR_NINE) begin
      digit_val = sym - CHAR_ZERO;
      push_operand({24'd0, digit_val});
    end else begin
      rhs = pop_operand();
      lhs = pop_operand();
      case (sym)
        CHAR_PLUS:  push_operand(lhs + rhs);
        CHAR_MINUS: push_operand(lhs - rhs);
        CHAR_STAR:  push_operand(lhs * rhs);
        CHAR_SLASH: begin
          if (rhs == 32'd0) begin
            record_fault(ST_DIVZ);
            push_operand(32'd0);
          end else begin
            push_operand(trunc_quotient(lhs, rhs));
          end
        end
        default: ;  // drop both operands
      endcase
    end
    if (!last) begin
      return 1'b0;
    end
    if (eval_depth == 0) begin
      record_fault(ST_UNDER);
    end else begin
      res.value = eval_stack[eval_depth - 1];
    end
    res.status  = eval_status;
    eval_depth  = 0;
    eval_status = ST_OK;
    return 1'b1;
  endfunction

  function automatic logic [7:0] dig(input int unsigned n);
    return CHAR_ZERO + n[7:0];
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 3))
      0:       return CHAR_PLUS;
      1:       return CHAR_MINUS;
      2:       return CHAR_STAR;
      default: return CHAR_SLASH;
    endcase
  endfunction

  // Drive one transaction from a falling edge, predict on acceptance,
  // return on the next falling edge with valid still high
  task automatic send_symbol(input logic [7:0] sym, input logic last, input logic typed,
                             input result_t fixed);
    result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    symbol_i   <= sym;
    last_i     <= last;
    do @(posedge clk_i); while (!in_ready_o);
    if (eval_symbol(sym, last, res)) begin
      if (typed) begin
        res = fixed;
      end
      pending_results.push_back(res);
      status_tally[res.status]++;
      expr_results++;
    end
    chars_sent++;
    // Step through the idle profiles
    if (chars_sent >= 2 * PHASE_LEN) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end else if (chars_sent >= PHASE_LEN) begin
      send_idle_pct = 80;
      recv_idle_pct = 34;
    end
    @(negedge clk_i);
  endtask

  // Fill expr_chars with one random expression
  task automatic build_expression();
    int unsigned kind;
    int unsigned n_operands;
    int unsigned pushed;
    int unsigned depth;
    int unsigned n_ops;
    expr_chars.delete();
    kind = $urandom_range(0, 99);
    if (kind < 77) begin
      // Well-formed: operands and operators leave exactly one value
      n_operands = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
      pushed = 0;
      depth  = 0;
      while (!(pushed == n_operands && depth == 1)) begin
        if (pushed < n_operands && (depth < 2 || $urandom_range(0, 1) == 1)) begin
          expr_chars.push_back('{dig($urandom_range(0, 9)), 1'b0});
          pushed++;
          depth++;
        end else begin
          expr_chars.push_back('{pick_operator(), 1'b0});
          depth--;
        end
      end
    end else if (kind < 80) begin
      // Deep stack: runs near or past the full mark, then folds down
      n_operands = $urandom_range(60, 70);
      n_ops      = $urandom_range(0, 72);
      repeat (n_operands) expr_chars.push_back('{dig($urandom_range(0, 9)), 1'b0});
      repeat (n_ops) expr_chars.push_back('{pick_operator(), 1'b0});
    end else begin
      // Noise: any byte, digits and operators in no order
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 3))
          0, 1:    expr_chars.push_back('{8'($urandom_range(0, 255)), 1'b0});
          2:       expr_chars.push_back('{dig($urandom_range(0, 9)), 1'b0});
          default: expr_chars.push_back('{pick_operator(), 1'b0});
        endcase
      end
    end
    expr_chars[expr_chars.size() - 1].last = 1'b1;
  endtask

  // Compare each delivered result with the oldest expectation
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_failure($sformatf("unexpected result value=%0d status=%0d",
                                 value_o, status_o));
      end else begin
        want = pending_results.pop_front();
        if (value_o !== want.value || status_o !== want.status) begin
          report_failure($sformatf("value exp %0d got %0d, status exp %0d got %0d",
                                   $signed(want.value), value_o, want.status, status_o));
        end
      end
    end
  end

  initial begin
    int unsigned directed_chars;
    int unsigned waited;
    directed_tbl = '{
      // empty stack at the end
      '{CHAR_PLUS,  7'd1,  1'b1, 1'b1, 32'd0, ST_UNDER},
      // single digits at both ends of the range
      '{CHAR_NINE,  7'd1,  1'b1, 1'b1, 32'd9, ST_OK},
      '{dig(0),     7'd1,  1'b1, 1'b1, 32'd0, ST_OK},
      // other characters, lowest and highest byte, drop their operands
      '{dig(5),     7'd1,  1'b0, 1'b0, 32'd0, ST_OK},
      '{dig(6),     7'd1,  1'b0, 1'b0, 32'd0, ST_OK},
      '{8'h00,      7'd1,  1'b0, 1'b0, 32'd0, ST_OK},
      '{dig(7),     7'd1,  1'b0, 1'b0, 32'd0, ST_OK},
      '{dig(8),     7'd1,  1'b0, 1'b0, 32'd0, ST_OK},
      '{8'hFF,      7'd1,  1'b1, 1'b1, 32'd0, ST_UNDER},
      // subtract
      '{dig(7),     7'd1,  1'b0, 1'b0, 32'd0, ST_OK},
      '{dig(3),     7'd1,  1'b0, 1'b0, 32'd0, ST_OK},
      '{CHAR_MINUS, 7'd1,  1'b1, 1'b0, 32'd0, ST_OK},
      // divide by zero
      '{dig(8),     7'd1,  1'b0, 1'b0, 32'd0, ST_OK},
      '{dig(0),     7'd1,  1'b0, 1'b0, 32'd0, ST_OK},
      '{CHAR_SLASH, 7'd1,  1'b1, 1'b1, 32'd0, ST_DIVZ},
      // negative quotient truncates toward zero
      '{dig(3),     7'd1,  1'b0, 1'b0, 32'd0, ST_OK},
      '{dig(9),     7'd1,  1'b0, 1'b0, 32'd0, ST_OK},
      '{CHAR_MINUS, 7'd1,  1'b0, 1'b0, 32'd0, ST_OK},
      '{dig(4),     7'd1,  1'b0, 1'b0, 32'd0, ST_OK},
      '{CHAR_SLASH, 7'd1,  1'b1, 1'b0, 32'd0, ST_OK},
      // two digits past a full stack are dropped
      '{dig(1),     7'd66, 1'b0, 1'b0, 32'd0, ST_OK},
      '{CHAR_PLUS,  7'd1,  1'b1, 1'b1, 32'd2, ST_OVER},
      // divide by zero then underflow: the first fault stays
      '{dig(8),     7'd1,  1'b0, 1'b0, 32'd0, ST_OK},
      '{dig(0),     7'd1,  1'b0, 1'b0, 32'd0, ST_OK},
      '{CHAR_SLASH, 7'd1,  1'b0, 1'b0, 32'd0, ST_OK},
      '{CHAR_PLUS,  7'd1,  1'b1, 1'b0, 32'd0, ST_OK},
      // 8^10 * 2 is the most negative value; divided by -1 it wraps
      '{dig(8),     7'd10, 1'b0, 1'b0, 32'd0, ST_OK},
      '{CHAR_STAR,  7'd9,  1'b0, 1'b0, 32'd0, ST_OK},
      '{dig(2),     7'd1,  1'b0, 1'b0, 32'd0, ST_OK},
      '{CHAR_STAR,  7'd1,  1'b0, 1'b0, 32'd0, ST_OK},
      '{dig(0),     7'd1,  1'b0, 1'b0, 32'd0, ST_OK},
      '{dig(1),     7'd1,  1'b0, 1'b0, 32'd0, ST_OK},
      '{CHAR_MINUS, 7'd1,  1'b0, 1'b0, 32'd0, ST_OK},
      '{CHAR_SLASH, 7'd1,  1'b1, 1'b1, 32'h8000_0000, ST_OK}
    };

    wait (rst_ni);
    @(negedge clk_i);

    // Walk the directed table
    foreach (directed_tbl[r]) begin
      for (int n = 0; n < directed_tbl[r].reps; n++) begin
        send_symbol(directed_tbl[r].sym,
                    directed_tbl[r].last && (n == directed_tbl[r].reps - 1),
                    directed_tbl[r].typed,
                    result_t'{directed_tbl[r].value, directed_tbl[r].status});
      end
    end
    directed_chars = chars_sent;

    // Random expressions
    while (random_chars < NUM_RANDOM) begin
      build_expression();
      foreach (expr_chars[k]) begin
        send_symbol(expr_chars[k].sym, expr_chars[k].last, 1'b0, '0);
      end
      random_chars += expr_chars.size();
    end
    in_valid_i <= 1'b0;

    // Drain outstanding results, then watch for strays
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      report_failure($sformatf("%0d expected results never arrived", pending_results.size()));
    end

    $display("Run covered %0d characters (%0d directed, %0d random) in %0d expressions.",
             chars_sent, directed_chars, random_chars, expr_results);
    $display("Statuses: %0d ok, %0d underflow, %0d divide by zero, %0d overflow; %0d failures.",
             status_tally[ST_OK], status_tally[ST_UNDER], status_tally[ST_DIVZ],
             status_tally[ST_OVER], check_errors);
    if (check_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
